[hw/rtl/qrv_pkg.sv]
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared types and widths for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
package qrv_pkg;

  localparam int DATA_W        = 16;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int P_W           = PROD_W + 1;
  localparam int PQ_W          = P_W + DATA_W;
  localparam int R_W           = PQ_W + 2;
  localparam int QRV_FRAC_BITS = 15;

  typedef enum logic [1:0] {
    REG_QUAT_W = 2'd0,
    REG_QUAT_X = 2'd1,
    REG_QUAT_Y = 2'd2,
    REG_QUAT_Z = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
  } vec_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rot_x;
    logic signed [DATA_W-1:0] rot_y;
    logic signed [DATA_W-1:0] rot_z;
    logic                     clipped;
  } rot_t;

  // first Hamilton product q * (0, v)
  typedef struct packed {
    logic signed [P_W-1:0] w;
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
  } pquat_t;

  // vector part of p * conj(q), scaled by 2^(2*FRAC_BITS)
  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

endpackage

[hw/rtl/qrv_prod1.sv]
// ----------------------------------------------------------------------------
// qrv_prod1
// First Hamilton product p = q * (0, v): multiply stage, then sum stage.
// ----------------------------------------------------------------------------
module qrv_prod1 (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  qrv_pkg::vec_t  v,
  input  qrv_pkg::quat_t q,
  output logic           p_valid,
  output qrv_pkg::pquat_t p
);
  import qrv_pkg::*;

  logic                     m_valid;
  logic signed [PROD_W-1:0] m [12];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      m_valid <= in_valid;
      p_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    m[0]  <= PROD_W'(q.x * v.vec_x);
    m[1]  <= PROD_W'(q.y * v.vec_y);
    m[2]  <= PROD_W'(q.z * v.vec_z);
    m[3]  <= PROD_W'(q.w * v.vec_x);
    m[4]  <= PROD_W'(q.y * v.vec_z);
    m[5]  <= PROD_W'(q.z * v.vec_y);
    m[6]  <= PROD_W'(q.w * v.vec_y);
    m[7]  <= PROD_W'(q.x * v.vec_z);
    m[8]  <= PROD_W'(q.z * v.vec_x);
    m[9]  <= PROD_W'(q.w * v.vec_z);
    m[10] <= PROD_W'(q.x * v.vec_y);
    m[11] <= PROD_W'(q.y * v.vec_x);
  end

  always_ff @(posedge clk) begin
    p.w <= -P_W'(m[0]) - P_W'(m[1])  - P_W'(m[2]);
    p.x <=  P_W'(m[3]) + P_W'(m[4])  - P_W'(m[5]);
    p.y <=  P_W'(m[6]) - P_W'(m[7])  + P_W'(m[8]);
    p.z <=  P_W'(m[9]) + P_W'(m[10]) - P_W'(m[11]);
  end

endmodule

[hw/rtl/qrv_prod2.sv]
// ----------------------------------------------------------------------------
// qrv_prod2
// Vector part of r = p * conj(q): multiply stage, then sum stage.
// ----------------------------------------------------------------------------
module qrv_prod2 (
  input  logic            clk,
  input  logic            rst,
  input  logic            p_valid,
  input  qrv_pkg::pquat_t p,
  input  qrv_pkg::quat_t  q,
  output logic            r_valid,
  output qrv_pkg::rvec_t  r
);
  import qrv_pkg::*;

  logic                   n_valid;
  logic signed [PQ_W-1:0] n [12];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
      r_valid <= 1'b0;
    end else begin
      n_valid <= p_valid;
      r_valid <= n_valid;
    end
  end

  always_ff @(posedge clk) begin
    n[0]  <= PQ_W'(p.w * q.x);
    n[1]  <= PQ_W'(p.x * q.w);
    n[2]  <= PQ_W'(p.y * q.z);
    n[3]  <= PQ_W'(p.z * q.y);
    n[4]  <= PQ_W'(p.w * q.y);
    n[5]  <= PQ_W'(p.x * q.z);
    n[6]  <= PQ_W'(p.y * q.w);
    n[7]  <= PQ_W'(p.z * q.x);
    n[8]  <= PQ_W'(p.w * q.z);
    n[9]  <= PQ_W'(p.x * q.y);
    n[10] <= PQ_W'(p.y * q.x);
    n[11] <= PQ_W'(p.z * q.w);
  end

  always_ff @(posedge clk) begin
    r.x <= -R_W'(n[0]) + R_W'(n[1])  - R_W'(n[2])  + R_W'(n[3]);
    r.y <= -R_W'(n[4]) + R_W'(n[5])  + R_W'(n[6])  - R_W'(n[7]);
    r.z <= -R_W'(n[8]) - R_W'(n[9])  + R_W'(n[10]) + R_W'(n[11]);
  end

endmodule

[hw/rtl/qrv_round.sv]
// ----------------------------------------------------------------------------
// qrv_round
// Round to nearest (ties up), drop 2*FRAC_BITS fraction bits, saturate to
// 16 bits and register the result with its strobe.
// ----------------------------------------------------------------------------
module qrv_round #(
  parameter int FRAC_BITS = qrv_pkg::QRV_FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           r_valid,
  input  qrv_pkg::rvec_t r,
  output logic           done,
  output qrv_pkg::rot_t  result
);
  import qrv_pkg::*;

  localparam int SHIFT = 2 * FRAC_BITS;
  localparam int ACC_W = (SHIFT + 2 > R_W + 1) ? SHIFT + 2 : R_W + 1;
  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (SHIFT - 1);
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MINV = -ACC_W'(32768);

  // returns {saturated, value}
  function automatic logic [DATA_W:0] finish(input logic signed [R_W-1:0] s);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] qv;
    logic [DATA_W:0]         res;
    acc = ACC_W'(s) + RND;
    qv  = acc >>> SHIFT;
    if (qv > MAXV) begin
      res = {1'b1, MAXV[DATA_W-1:0]};
    end else if (qv < MINV) begin
      res = {1'b1, MINV[DATA_W-1:0]};
    end else begin
      res = {1'b0, qv[DATA_W-1:0]};
    end
    return res;
  endfunction

  logic [DATA_W:0] fx;
  logic [DATA_W:0] fy;
  logic [DATA_W:0] fz;
  rot_t            result_next;

  always_comb begin
    fx = finish(r.x);
    fy = finish(r.y);
    fz = finish(r.z);
    result_next.rot_x   = fx[DATA_W-1:0];
    result_next.rot_y   = fy[DATA_W-1:0];
    result_next.rot_z   = fz[DATA_W-1:0];
    result_next.clipped = fx[DATA_W] | fy[DATA_W] | fz[DATA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

[hw/rtl/quaternion_rotate_vector.sv]
// Throughput: one transaction per cycle; busy stays low, so start may be held high.
// Six register stages: input, q*v multiply, sum, p*conj(q) multiply, sum, round/saturate.
// Reset (rst, synchronous) clears all valid bits and loads the identity quaternion.
// done marks each result for exactly one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a 3-D vector by the configured quaternion, computing q * v * conj(q).
// ----------------------------------------------------------------------------
module quaternion_rotate_vector #(
  parameter int FRAC_BITS = qrv_pkg::QRV_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  qrv_pkg::vec_t             vec,
  output logic                      done,
  output qrv_pkg::rot_t             result,
  input  logic                      wr_en,
  input  logic [1:0]                wr_index,
  input  logic [qrv_pkg::DATA_W-1:0] wr_data
);
  import qrv_pkg::*;

  quat_t  q;
  logic   in_valid;
  vec_t   v;
  logic   p_valid;
  pquat_t p;
  logic   r_valid;
  rvec_t  r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.w <= 16'sh7FFF;
      q.x <= '0;
      q.y <= '0;
      q.z <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_QUAT_W: q.w <= wr_data;
        REG_QUAT_X: q.x <= wr_data;
        REG_QUAT_Y: q.y <= wr_data;
        REG_QUAT_Z: q.z <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    v <= vec;
  end

  qrv_prod1 u_prod1 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .v        (v),
    .q        (q),
    .p_valid  (p_valid),
    .p        (p)
  );

  qrv_prod2 u_prod2 (
    .clk     (clk),
    .rst     (rst),
    .p_valid (p_valid),
    .p       (p),
    .q       (q),
    .r_valid (r_valid),
    .r       (r)
  );

  qrv_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk     (clk),
    .rst     (rst),
    .r_valid (r_valid),
    .r       (r),
    .done    (done),
    .result  (result)
  );

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 6))
    else $error("result strobe without a matching transaction");

  a_txn_completes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##6 done)
    else $error("accepted transaction produced no result");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    (done && result.clipped) |->
      (result.rot_x == 16'sh7FFF || result.rot_x == 16'sh8000 ||
       result.rot_y == 16'sh7FFF || result.rot_y == 16'sh8000 ||
       result.rot_z == 16'sh7FFF || result.rot_z == 16'sh8000))
    else $error("clipped set but no component at a limit");

endmodule
